### hw/rtl/cmdp_pkg.sv
package cmdp_pkg;

   // parameter defaults
   localparam int FIELD_COUNT_DEF = 4;
   localparam int VALUE_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   // fixed widths of the transaction fields
   localparam int BYTE_BITS  = 8;
   localparam int CMD_BITS   = 4;
   localparam int DIGIT_BITS = 4;
   localparam int OUT_BITS   = 16;
   localparam int OUT_FIELDS = 4;

   // received characters
   localparam logic [BYTE_BITS-1:0] CHR_DOLLAR = 8'h24;
   localparam logic [BYTE_BITS-1:0] CHR_A      = 8'h41;
   localparam logic [BYTE_BITS-1:0] CHR_M      = 8'h4D;
   localparam logic [BYTE_BITS-1:0] CHR_S      = 8'h53;
   localparam logic [BYTE_BITS-1:0] CHR_MINUS  = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CHR_PCT    = 8'h25;
   localparam logic [BYTE_BITS-1:0] CHR_ZERO   = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHR_NINE   = 8'h39;
   localparam logic [BYTE_BITS-1:0] CHR_E      = 8'h45;
   localparam logic [BYTE_BITS-1:0] CHR_I      = 8'h49;
   localparam logic [BYTE_BITS-1:0] CHR_W      = 8'h57;
   localparam logic [BYTE_BITS-1:0] CHR_P      = 8'h50;
   localparam logic [BYTE_BITS-1:0] CHR_V      = 8'h56;
   localparam logic [BYTE_BITS-1:0] CHR_C      = 8'h43;
   localparam logic [BYTE_BITS-1:0] CHR_T      = 8'h54;
   localparam logic [BYTE_BITS-1:0] CHR_G      = 8'h47;

   // command codes on the result channel
   localparam logic [CMD_BITS-1:0] CMD_DOLLAR = 4'd0;
   localparam logic [CMD_BITS-1:0] CMD_A      = 4'd1;
   localparam logic [CMD_BITS-1:0] CMD_M      = 4'd2;
   localparam logic [CMD_BITS-1:0] CMD_E      = 4'd3;
   localparam logic [CMD_BITS-1:0] CMD_I      = 4'd4;
   localparam logic [CMD_BITS-1:0] CMD_W      = 4'd5;
   localparam logic [CMD_BITS-1:0] CMD_P      = 4'd6;
   localparam logic [CMD_BITS-1:0] CMD_V      = 4'd7;
   localparam logic [CMD_BITS-1:0] CMD_C      = 4'd8;
   localparam logic [CMD_BITS-1:0] CMD_T      = 4'd9;
   localparam logic [CMD_BITS-1:0] CMD_G      = 4'd10;

   // classified character kinds
   typedef enum logic [2:0] {
      TOK_IMM,
      TOK_START,
      TOK_MINUS,
      TOK_DIGIT,
      TOK_SEP,
      TOK_LAST
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type            kind;
      logic [DIGIT_BITS-1:0]   digit;
      logic [CMD_BITS-1:0]     cmd;
   } token_type;

endpackage

### hw/rtl/cmdp_front.sv
module cmdp_front
   import cmdp_pkg::*;
(
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_BITS-1:0] req_rx_byte,
   output logic                 push_valid,
   output token_type            push_tok,
   input  logic                 queue_full
);

   logic known;

   // the queue back-pressures the byte stream
   assign req_stall = queue_full;

   // classify the received character
   always_comb begin
      known          = 1'b1;
      push_tok.kind  = TOK_IMM;
      push_tok.digit = req_rx_byte[DIGIT_BITS-1:0];
      push_tok.cmd   = CMD_DOLLAR;
      case (req_rx_byte)
         CHR_DOLLAR: push_tok.cmd = CMD_DOLLAR;
         CHR_A:      push_tok.cmd = CMD_A;
         CHR_M:      push_tok.cmd = CMD_M;
         CHR_S:      push_tok.kind = TOK_START;
         CHR_MINUS:  push_tok.kind = TOK_MINUS;
         CHR_PCT:    push_tok.kind = TOK_SEP;
         CHR_E: begin
            push_tok.kind = TOK_LAST;
            push_tok.cmd  = CMD_E;
         end
         CHR_I: begin
            push_tok.kind = TOK_LAST;
            push_tok.cmd  = CMD_I;
         end
         CHR_W: begin
            push_tok.kind = TOK_LAST;
            push_tok.cmd  = CMD_W;
         end
         CHR_P: begin
            push_tok.kind = TOK_LAST;
            push_tok.cmd  = CMD_P;
         end
         CHR_V: begin
            push_tok.kind = TOK_LAST;
            push_tok.cmd  = CMD_V;
         end
         CHR_C: begin
            push_tok.kind = TOK_LAST;
            push_tok.cmd  = CMD_C;
         end
         CHR_T: begin
            push_tok.kind = TOK_LAST;
            push_tok.cmd  = CMD_T;
         end
         CHR_G: begin
            push_tok.kind = TOK_LAST;
            push_tok.cmd  = CMD_G;
         end
         default: begin
            if (req_rx_byte >= CHR_ZERO && req_rx_byte <= CHR_NINE) begin
               push_tok.kind = TOK_DIGIT;
            end else begin
               known = 1'b0;
            end
         end
      endcase
   end

   // meaningless characters are taken and dropped here
   assign push_valid = req_valid && !queue_full && known;

endmodule

### hw/rtl/cmdp_queue.sv
module cmdp_queue
   import cmdp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  token_type push_tok,
   output logic      full,
   output logic      pop_valid,
   output token_type pop_tok,
   input  logic      pop
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   token_type             slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_tok   = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // token storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

### hw/rtl/cmdp_back.sv
module cmdp_back
   import cmdp_pkg::*;
#(
   parameter int FIELD_COUNT = FIELD_COUNT_DEF,
   parameter int VALUE_BITS  = VALUE_BITS_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tok_valid,
   input  token_type                  tok,
   output logic                       tok_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [CMD_BITS-1:0]        rsp_command,
   output logic signed [OUT_BITS-1:0] rsp_value_a,
   output logic signed [OUT_BITS-1:0] rsp_value_b,
   output logic signed [OUT_BITS-1:0] rsp_value_c,
   output logic signed [OUT_BITS-1:0] rsp_value_d
);

   localparam int PHASE_BITS = $clog2(FIELD_COUNT + 1);
   localparam int IDX_BITS   = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] acc_ff [FIELD_COUNT];
   logic [VALUE_BITS-1:0] acc_in [FIELD_COUNT];
   logic [VALUE_BITS-1:0] closed [FIELD_COUNT];
   logic [VALUE_BITS-1:0] stepped [FIELD_COUNT];
   logic [IDX_BITS-1:0]   idx;
   logic                  collecting;
   logic                  last_phase;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CMD_BITS-1:0]   cmd_ff, cmd_in;
   logic [OUT_BITS-1:0]   val_ff [OUT_FIELDS];
   logic [OUT_BITS-1:0]   val_in [OUT_FIELDS];
   logic [OUT_BITS-1:0]   field_out [OUT_FIELDS];
   logic                  emit;
   logic                  emit_vals;

   // take a token whenever the output register is free or being drained
   assign tok_pop = tok_valid && (!rsp_valid_ff || !rsp_stall);

   assign idx        = IDX_BITS'(phase_ff - PHASE_BITS'(1));
   assign collecting = (phase_ff != '0) && (phase_ff <= PHASE_BITS'(FIELD_COUNT));
   assign last_phase = (phase_ff == PHASE_BITS'(FIELD_COUNT));

   // per-field lanes: digit accumulate and sign application
   always_comb begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
         stepped[i] = (acc_ff[i] << 3) + (acc_ff[i] << 1) + VALUE_BITS'(tok.digit);
         if (neg_ff && IDX_BITS'(i) == idx) begin
            closed[i] = '0 - acc_ff[i];
         end else begin
            closed[i] = acc_ff[i];
         end
      end
   end

   // low result bits of each field, zero beyond the field count
   for (genvar j = 0; j < OUT_FIELDS; j++) begin : g_out
      if (j < FIELD_COUNT) begin : g_used
         logic [VALUE_BITS+OUT_BITS-1:0] wide;
         assign wide         = {{OUT_BITS{1'b0}}, closed[j]};
         assign field_out[j] = wide[OUT_BITS-1:0];
      end else begin : g_unused
         assign field_out[j] = '0;
      end
   end

   // parser state update
   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      emit      = 1'b0;
      emit_vals = 1'b0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
         acc_in[i] = acc_ff[i];
      end
      if (tok_pop) begin
         case (tok.kind)
            TOK_IMM: begin
               emit = 1'b1;
            end
            TOK_START: begin
               if (phase_ff == '0) begin
                  phase_in = PHASE_BITS'(1);
                  for (int i = 0; i < FIELD_COUNT; i++) begin
                     acc_in[i] = '0;
                  end
               end
            end
            TOK_MINUS: begin
               if (collecting) begin
                  neg_in = 1'b1;
               end
            end
            TOK_DIGIT: begin
               if (collecting) begin
                  for (int i = 0; i < FIELD_COUNT; i++) begin
                     if (IDX_BITS'(i) == idx) begin
                        acc_in[i] = stepped[i];
                     end
                  end
               end
            end
            TOK_SEP: begin
               if (collecting && !last_phase) begin
                  phase_in = phase_ff + 1'b1;
                  neg_in   = 1'b0;
                  for (int i = 0; i < FIELD_COUNT; i++) begin
                     acc_in[i] = closed[i];
                  end
               end
            end
            TOK_LAST: begin
               if (last_phase) begin
                  phase_in  = '0;
                  neg_in    = 1'b0;
                  emit      = 1'b1;
                  emit_vals = 1'b1;
                  for (int i = 0; i < FIELD_COUNT; i++) begin
                     acc_in[i] = closed[i];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // output register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      cmd_in       = cmd_ff;
      for (int j = 0; j < OUT_FIELDS; j++) begin
         val_in[j] = val_ff[j];
      end
      if (tok_pop) begin
         rsp_valid_in = emit;
         cmd_in       = tok.cmd;
         for (int j = 0; j < OUT_FIELDS; j++) begin
            val_in[j] = emit_vals ? field_out[j] : '0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      for (int j = 0; j < OUT_FIELDS; j++) begin
         val_ff[j] <= val_in[j];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = cmd_ff;
   assign rsp_value_a = val_ff[0];
   assign rsp_value_b = val_ff[1];
   assign rsp_value_c = val_ff[2];
   assign rsp_value_d = val_ff[3];

endmodule

### hw/rtl/ascii_signed_field_command_parser.sv
// Parses an ASCII byte stream into commands with up to four signed decimal fields.
// A byte can be accepted every clock cycle while req_stall is low. The accepting edge
// writes the classified byte into the token queue; the executing stage pops it from
// there, runs the accumulate step and loads the result register. The classifier in
// front is combinational. While rsp_stall holds a result, the executing stage waits,
// the token queue of QUEUE_DEPTH entries fills and req_stall rises; with the result
// side free and QUEUE_DEPTH above one, req_stall stays low. Bytes that mean
// nothing are taken and dropped. '$', 'A' and 'M' give an immediate command with zero
// values; "S f0 % f1 % f2 % f3 X" with X one of E I W P V C T G gives command X with the
// four fields, each wrapping modulo 2^VALUE_BITS and shown as its low 16 bits.
module ascii_signed_field_command_parser
   import cmdp_pkg::*;
#(
   parameter int FIELD_COUNT = FIELD_COUNT_DEF,
   parameter int VALUE_BITS  = VALUE_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [BYTE_BITS-1:0]       req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [CMD_BITS-1:0]        rsp_command,
   output logic signed [OUT_BITS-1:0] rsp_value_a,
   output logic signed [OUT_BITS-1:0] rsp_value_b,
   output logic signed [OUT_BITS-1:0] rsp_value_c,
   output logic signed [OUT_BITS-1:0] rsp_value_d
);

   logic      push_valid;
   token_type push_tok;
   logic      queue_full;
   logic      tok_valid;
   token_type tok;
   logic      tok_pop;

   // character classifier
   cmdp_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .push_valid  (push_valid),
      .push_tok    (push_tok),
      .queue_full  (queue_full)
   );

   // token queue between classifier and executer
   cmdp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_tok   (push_tok),
      .full       (queue_full),
      .pop_valid  (tok_valid),
      .pop_tok    (tok),
      .pop        (tok_pop)
   );

   // field accumulation and command output
   cmdp_back #(
      .FIELD_COUNT (FIELD_COUNT),
      .VALUE_BITS  (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .tok_valid   (tok_valid),
      .tok         (tok),
      .tok_pop     (tok_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_command (rsp_command),
      .rsp_value_a (rsp_value_a),
      .rsp_value_b (rsp_value_b),
      .rsp_value_c (rsp_value_c),
      .rsp_value_d (rsp_value_d)
   );

endmodule

### hw/rtl/cmdp_checker.sv
module cmdp_checker
   import cmdp_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [CMD_BITS-1:0]        rsp_command,
   input logic signed [OUT_BITS-1:0] rsp_value_a,
   input logic signed [OUT_BITS-1:0] rsp_value_b,
   input logic signed [OUT_BITS-1:0] rsp_value_c,
   input logic signed [OUT_BITS-1:0] rsp_value_d
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command) && $stable(rsp_value_a))
      else $error("stalled result changed");

   // only defined command codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_command <= CMD_G)
      else $error("undefined command code");

   // immediate commands carry zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == CMD_DOLLAR || rsp_command == CMD_A ||
                    rsp_command == CMD_M)
      |-> rsp_value_a == '0 && rsp_value_b == '0 && rsp_value_c == '0 &&
          rsp_value_d == '0)
      else $error("immediate command with nonzero field");

   // reset empties the queue and the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state left after reset");

endmodule

bind ascii_signed_field_command_parser cmdp_checker u_checker (.*);
